// ===== rtl/sobel_edge_magnitude_unit_macros.svh =====
// assertion macros shared by the sobel edge magnitude rtl
// expects signals named clk and rst_n in the module that uses them
`ifndef SOBEL_EDGE_MAGNITUDE_UNIT_MACROS_SVH
`define SOBEL_EDGE_MAGNITUDE_UNIT_MACROS_SVH

// same-cycle implication, off during reset
`define SEM_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define SEM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/sem_pkg.sv =====
// shared constants and types of the sobel edge magnitude unit
// no dependencies; imported by the top level, sem_window and sem_outq
`default_nettype none

package sem_pkg;

  // frame size limits
  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 4096;
  localparam int MIN_DIM    = 3;

  // field widths
  localparam int PIX_W  = 8;
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int WCFG_W = 12;
  localparam int HCFG_W = 13;
  localparam int EDGE_MAX = 255;

  // configuration port
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = HCFG_W;
  localparam logic [WCFG_W-1:0] WIDTH_RESET  = WCFG_W'(640);
  localparam logic [HCFG_W-1:0] HEIGHT_RESET = HCFG_W'(480);

  // output queue
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // result tdata packing
  localparam int OUT_USED_W  = ROW_W + COL_W + PIX_W;
  localparam int OUT_TDATA_W = ((OUT_USED_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_USED_W;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_IMAGE_WIDTH  = 1'd0,
    REG_IMAGE_HEIGHT = 1'd1
  } cfg_reg_t;

  // position of an accepted item inside the frame
  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             col_end;
    logic             row_end;
  } pos_t;

  // one queued entry: base result plus border expansion flags
  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [PIX_W-1:0] grad;
    logic             col_end;
    logic             row_end;
  } bundle_t;

  // which result of an entry is on the output
  typedef enum logic [1:0] {
    PH_BASE,
    PH_COL_END,
    PH_ROW_END,
    PH_CORNER
  } phase_t;

endpackage

`default_nettype wire

// ===== rtl/sobel_edge_magnitude_unit.sv =====
// sobel edge magnitude unit, top level
// depends on sem_pkg, sem_window, sem_outq
//
// usage:
//   in_*  : grey pixels (8 bit) in raster order, one item per handshake.
//   out_* : results |Gx|+|Gy| saturated to 255, with row and column of the
//           result pixel; border pixels give 0. tlast marks the last result
//           caused by one input item, tuser marks the last result of a frame.
//   cfg_* : write image_width (index 0) and image_height (index 1) only while
//           the block is idle; values are clamped to 3..2048 and 3..4096.
// path: an item is accepted, held in the memory read stage, then queued for output.
// throughput: one item per cycle, set by the single read and write port of each
//   line memory. An item in the last column or last row, if it gives a result at all,
//   expands to two to four results, one per output cycle; a four-entry result queue
//   absorbs them and in_tready drops when it cannot take one more item.
// reset: position counters go to zero, size registers to 640 x 480, the window
//   to zero and the queue empties; line memories are not cleared, their stale
//   content only feeds border results, so no clearing pass is run.
// receiver stall: results wait in the queue; once it fills, input is held off.
`default_nettype none

module sobel_edge_magnitude_unit (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  input  wire logic [sem_pkg::PIX_W-1:0]          in_tdata,   // pixel_in
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  output logic [sem_pkg::OUT_TDATA_W-1:0]         out_tdata,  // out_row, out_col, edge_value
  output logic                                    out_tlast,  // run_last
  output logic                                    out_tuser,  // frame_last
  input  wire logic                               cfg_we,
  input  wire logic [sem_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  wire logic [sem_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import sem_pkg::*;

  logic [WCFG_W-1:0] image_width_r;
  logic [HCFG_W-1:0] image_height_r;
  logic [WCFG_W-1:0] w_use;
  logic [HCFG_W-1:0] h_use;
  logic [COL_W-1:0]  wm1;
  logic [ROW_W-1:0]  hm1;
  logic [COL_W-1:0]  col_count_r, col_count_nxt, col_eff;
  logic [ROW_W-1:0]  row_count_r, row_count_nxt, row_eff;
  pos_t              pos;
  logic              acc;
  logic              busy, push, space_ok;
  bundle_t           push_data;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= WIDTH_RESET;
      image_height_r <= HEIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_IMAGE_WIDTH:  image_width_r  <= cfg_wdata[WCFG_W-1:0];
        REG_IMAGE_HEIGHT: image_height_r <= cfg_wdata[HCFG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // frame size in use
  always_comb begin
    if (image_width_r < WCFG_W'(MIN_DIM)) begin
      w_use = WCFG_W'(MIN_DIM);
    end else if (image_width_r > WCFG_W'(MAX_WIDTH)) begin
      w_use = WCFG_W'(MAX_WIDTH);
    end else begin
      w_use = image_width_r;
    end
    if (image_height_r < HCFG_W'(MIN_DIM)) begin
      h_use = HCFG_W'(MIN_DIM);
    end else if (image_height_r > HCFG_W'(MAX_HEIGHT)) begin
      h_use = HCFG_W'(MAX_HEIGHT);
    end else begin
      h_use = image_height_r;
    end
  end

  assign wm1 = COL_W'(w_use - WCFG_W'(1));
  assign hm1 = ROW_W'(h_use - HCFG_W'(1));

  // position of the next item, restarted when beyond the size in use
  assign col_eff = (col_count_r > wm1) ? '0 : col_count_r;
  assign row_eff = (row_count_r > hm1) ? '0 : row_count_r;

  always_comb begin
    pos.row     = row_eff;
    pos.col     = col_eff;
    pos.col_end = (col_eff == wm1);
    pos.row_end = (row_eff == hm1);
  end

  always_comb begin
    col_count_nxt = col_eff + COL_W'(1);
    row_count_nxt = row_eff;
    if (pos.col_end) begin
      col_count_nxt = '0;
      row_count_nxt = pos.row_end ? '0 : row_eff + ROW_W'(1);
    end
  end

  assign in_tready = space_ok;
  assign acc = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_count_r <= '0;
      row_count_r <= '0;
    end else if (acc) begin
      col_count_r <= col_count_nxt;
      row_count_r <= row_count_nxt;
    end
  end

  sem_window u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_acc    (acc),
    .in_pix    (in_tdata),
    .in_pos    (pos),
    .busy      (busy),
    .push      (push),
    .push_data (push_data)
  );

  sem_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  (push_data),
    .inflight   (busy),
    .wm1        (wm1),
    .hm1        (hm1),
    .space_ok   (space_ok),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

`default_nettype wire

// ===== rtl/sem_ram.sv =====
// generic single-clock ram, one write port and one registered read port
// no dependencies
`default_nettype none

module sem_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== rtl/sem_window.sv =====
// line memories, 3x3 window and sobel gradient of the edge magnitude unit
// depends on sem_pkg, sem_ram and the shared assertion macros
`default_nettype none
`include "sobel_edge_magnitude_unit_macros.svh"

module sem_window (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_acc,
  input  wire logic [sem_pkg::PIX_W-1:0] in_pix,
  input  wire sem_pkg::pos_t           in_pos,
  output logic                         busy,
  output logic                         push,
  output sem_pkg::bundle_t             push_data
);
  import sem_pkg::*;

  logic             s1_valid_r;
  logic [PIX_W-1:0] s1_px_r;
  pos_t             s1_pos_r;
  logic [PIX_W-1:0] older_rd;
  logic [PIX_W-1:0] newer_rd;
  logic [PIX_W-1:0] win_r [6];
  logic [PIX_W+1:0] rgt_sum, lft_sum, bot_sum, top_sum;
  logic signed [PIX_W+2:0] gx, gy;
  logic [PIX_W+1:0] ax, ay;
  logic [PIX_W+2:0] mag;
  logic [PIX_W-1:0] sob;
  logic             emit, full;

  // line memories: read at accept, written back in the cycle after at the same column;
  // consecutive items never share a column, so no forwarding is needed
  sem_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_older (
    .clk   (clk),
    .we    (s1_valid_r),
    .waddr (s1_pos_r.col),
    .wdata (newer_rd),
    .re    (in_acc),
    .raddr (in_pos.col),
    .rdata (older_rd)
  );

  sem_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_newer (
    .clk   (clk),
    .we    (s1_valid_r),
    .waddr (s1_pos_r.col),
    .wdata (s1_px_r),
    .re    (in_acc),
    .raddr (in_pos.col),
    .rdata (newer_rd)
  );

  // item waiting for its memory read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_px_r  <= in_pix;
      s1_pos_r <= in_pos;
    end
  end

  // window shift: oldest column drops, current column enters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) begin
        win_r[i] <= '0;
      end
    end else if (s1_valid_r) begin
      win_r[0] <= win_r[3];
      win_r[1] <= win_r[4];
      win_r[2] <= win_r[5];
      win_r[3] <= older_rd;
      win_r[4] <= newer_rd;
      win_r[5] <= s1_px_r;
    end
  end

  // sobel kernels, columns left/mid are the window, right is the current column
  always_comb begin
    rgt_sum = {2'b00, older_rd} + {1'b0, newer_rd, 1'b0} + {2'b00, s1_px_r};
    lft_sum = {2'b00, win_r[0]} + {1'b0, win_r[1], 1'b0} + {2'b00, win_r[2]};
    bot_sum = {2'b00, win_r[2]} + {1'b0, win_r[5], 1'b0} + {2'b00, s1_px_r};
    top_sum = {2'b00, win_r[0]} + {1'b0, win_r[3], 1'b0} + {2'b00, older_rd};
    gx = $signed({1'b0, rgt_sum}) - $signed({1'b0, lft_sum});
    gy = $signed({1'b0, bot_sum}) - $signed({1'b0, top_sum});
    ax = gx[PIX_W+2] ? (PIX_W+2)'(-gx) : (PIX_W+2)'(gx);
    ay = gy[PIX_W+2] ? (PIX_W+2)'(-gy) : (PIX_W+2)'(gy);
    mag = {1'b0, ax} + {1'b0, ay};
    sob = (mag > (PIX_W+3)'(EDGE_MAX)) ? PIX_W'(EDGE_MAX) : mag[PIX_W-1:0];
  end

  // result position and border handling
  assign emit = (s1_pos_r.row != '0) && (s1_pos_r.col != '0);
  assign full = (s1_pos_r.row > ROW_W'(1)) && (s1_pos_r.col > COL_W'(1));

  always_comb begin
    push_data.row     = s1_pos_r.row - ROW_W'(1);
    push_data.col     = s1_pos_r.col - COL_W'(1);
    push_data.grad    = full ? sob : '0;
    push_data.col_end = s1_pos_r.col_end;
    push_data.row_end = s1_pos_r.row_end;
  end

  assign push = s1_valid_r && emit;
  assign busy = s1_valid_r;

  `SEM_ASSERT_SAME(a_no_same_col, s1_valid_r && in_acc, s1_pos_r.col != in_pos.col,
    "line memory read and write hit the same column")

endmodule

`default_nettype wire

// ===== rtl/sem_outq.sv =====
// result queue and border expansion of the edge magnitude unit
// depends on sem_pkg and the shared assertion macros
`default_nettype none
`include "sobel_edge_magnitude_unit_macros.svh"

module sem_outq (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          push,
  input  wire sem_pkg::bundle_t              push_data,
  input  wire logic                          inflight,
  input  wire logic [sem_pkg::COL_W-1:0]     wm1,
  input  wire logic [sem_pkg::ROW_W-1:0]     hm1,
  output logic                               space_ok,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [sem_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic                               out_tlast,
  output logic                               out_tuser
);
  import sem_pkg::*;

  bundle_t           q_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r, count_nxt;
  phase_t            phase_r, phase_nxt, succ;
  bundle_t           head;
  logic              last, fire, pop;
  logic [ROW_W-1:0]  o_row;
  logic [COL_W-1:0]  o_col;
  logic [PIX_W-1:0]  o_grad;

  assign head = q_r[rd_ptr_r];
  assign out_tvalid = (count_r != '0);
  assign fire = out_tvalid && out_tready;
  assign pop  = fire && last;

  // room for the item being accepted plus the one in the read stage
  assign space_ok = ({1'b0, count_r} + (QCNT_W+1)'(inflight)) < (QCNT_W+1)'(QDEPTH);

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_data;
    end
  end

  always_comb begin
    count_nxt = count_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
      phase_r  <= PH_BASE;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      count_r <= count_nxt;
      phase_r <= phase_nxt;
    end
  end

  // which result follows the current one in this entry
  always_comb begin
    succ = PH_BASE;
    last = 1'b1;
    unique case (phase_r)
      PH_BASE: begin
        if (head.col_end) begin
          succ = PH_COL_END;
          last = 1'b0;
        end else if (head.row_end) begin
          succ = PH_ROW_END;
          last = 1'b0;
        end
      end
      PH_COL_END: begin
        if (head.row_end) begin
          succ = PH_ROW_END;
          last = 1'b0;
        end
      end
      PH_ROW_END: begin
        if (head.col_end) begin
          succ = PH_CORNER;
          last = 1'b0;
        end
      end
      PH_CORNER: begin
        succ = PH_BASE;
        last = 1'b1;
      end
      default: begin
        succ = PH_BASE;
        last = 1'b1;
      end
    endcase
  end

  // next state
  always_comb begin
    phase_nxt = phase_r;
    if (fire) begin
      phase_nxt = last ? PH_BASE : succ;
    end
  end

  // result fields for the current state
  always_comb begin
    o_row     = head.row;
    o_col     = head.col;
    o_grad    = head.grad;
    out_tuser = 1'b0;
    unique case (phase_r)
      PH_BASE: begin
        o_grad = head.grad;
      end
      PH_COL_END: begin
        o_col  = wm1;
        o_grad = '0;
      end
      PH_ROW_END: begin
        o_row  = hm1;
        o_grad = '0;
      end
      PH_CORNER: begin
        o_row     = hm1;
        o_col     = wm1;
        o_grad    = '0;
        out_tuser = 1'b1;
      end
      default: begin
        o_grad = '0;
      end
    endcase
  end

  assign out_tdata = {{OUT_PAD_W{1'b0}}, o_grad, o_col, o_row};
  assign out_tlast = last;

  `SEM_ASSERT_SAME(a_no_overflow, push, (count_r < QCNT_W'(QDEPTH)) || pop,
    "result queue written while full")
  `SEM_ASSERT_SAME(a_phase_has_entry, phase_r != PH_BASE, count_r != '0,
    "border expansion running on an empty queue")
  `SEM_ASSERT_SAME(a_frame_end_is_run_end, out_tvalid && out_tuser, out_tlast,
    "frame end not marked as the last result of its item")
  `SEM_ASSERT_NEXT(a_pop_drains, pop && !push, count_r == $past(count_r) - QCNT_W'(1),
    "queue count did not drop after a pop")

endmodule

`default_nettype wire
